// ----- hdl/bna_pkg.sv -----
// Shared constants, codes and controller/datapath interface types for the node allocator.
package bna_pkg;

    localparam int MAX_NODES  = 1024;
    localparam int WORD_BITS  = 32;
    localparam int WORD_COUNT = MAX_NODES / WORD_BITS;
    localparam int IDX_W      = $clog2(MAX_NODES);
    localparam int CNT_W      = IDX_W + 1;
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int WADDR_W    = IDX_W - BIT_W;
    localparam int SCAN_W     = WADDR_W + 1;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_MARK  = 2'd1;
    localparam logic [1:0] OP_FREE  = 2'd2;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_SAME    = 2'd1;
    localparam logic [1:0] ST_RANGE   = 2'd2;
    localparam logic [1:0] ST_NO_FREE = 2'd3;

    localparam logic [CNT_W-1:0] NODE_COUNT_RESET = CNT_W'(MAX_NODES);

    typedef struct packed {
        logic accept;
        logic scan_start;
        logic scan_run;
        logic read_idx;
        logic alloc_hit;
        logic alloc_fail;
        logic range_err;
        logic same_state;
        logic toggle;
        logic publish;
    } bna_cmd_t;

    typedef struct packed {
        logic is_alloc;
        logic is_setclr;
        logic n_zero;
        logic idx_oor;
        logic scan_hit;
        logic scan_end;
        logic bit_match;
        logic out_free;
    } bna_stat_t;

endpackage

// ----- hdl/bna_ctrl.sv -----
// Sequencing state machine for the node allocator.
module bna_ctrl
    import bna_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  bna_stat_t stat,
    output bna_cmd_t  cmd
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_DECODE = 3'd1;
    localparam logic [2:0] S_SCAN   = 3'd2;
    localparam logic [2:0] S_CHECK  = 3'd3;
    localparam logic [2:0] S_FINISH = 3'd4;

    logic [2:0] state_reg;
    logic [2:0] state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (stat.is_alloc)
                begin
                    if (stat.n_zero)
                    begin
                        cmd.alloc_fail = 1'b1;
                        state_next     = S_FINISH;
                    end
                    else
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                end
                else if (stat.is_setclr && !stat.idx_oor)
                begin
                    cmd.read_idx = 1'b1;
                    state_next   = S_CHECK;
                end
                else
                begin
                    cmd.range_err = 1'b1;
                    state_next    = S_FINISH;
                end
            end
            S_SCAN:
            begin
                cmd.scan_run = 1'b1;
                if (stat.scan_hit)
                begin
                    cmd.alloc_hit = 1'b1;
                    state_next    = S_FINISH;
                end
                else if (stat.scan_end)
                begin
                    cmd.alloc_fail = 1'b1;
                    state_next     = S_FINISH;
                end
            end
            S_CHECK:
            begin
                if (stat.bit_match)
                begin
                    cmd.same_state = 1'b1;
                end
                else
                begin
                    cmd.toggle = 1'b1;
                end
                state_next = S_FINISH;
            end
            S_FINISH:
            begin
                if (stat.out_free)
                begin
                    cmd.publish = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ----- hdl/bna_dp.sv -----
// Datapath of the node allocator: bitmap memory, scan pipeline, counters and result register.
module bna_dp
    import bna_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  bna_cmd_t           cmd,
    output bna_stat_t          stat,
    input  logic [1:0]         opcode,
    input  logic [IDX_W-1:0]   node_index,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [IDX_W-1:0]   result_index,
    output logic [CNT_W-1:0]   free_count
);

    logic [WORD_BITS-1:0]  bitmap_mem [WORD_COUNT];
    logic [WORD_COUNT-1:0] word_valid_reg;
    logic [WORD_BITS-1:0]  rd_data_reg;
    logic                  rd_valid_reg;

    logic [CNT_W-1:0]   node_count_reg;
    logic [CNT_W-1:0]   total_reg;
    logic [1:0]         op_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [SCAN_W-1:0]  scan_reg;
    logic               chk_valid_reg;
    logic [WADDR_W-1:0] chk_addr_reg;
    logic [1:0]         res_status_reg;
    logic [IDX_W-1:0]   res_index_reg;
    logic               out_valid_reg;
    logic [1:0]         out_status_reg;
    logic [IDX_W-1:0]   out_index_reg;
    logic [CNT_W-1:0]   out_free_reg;

    logic [CNT_W-1:0]     n_eff;
    logic [CNT_W-1:0]     n_minus1;
    logic [WADDR_W-1:0]   last_word;
    logic [BIT_W-1:0]     lim_bit;
    logic [WORD_BITS-1:0] data_eff;
    logic [WORD_BITS-1:0] tail_mask;
    logic [WORD_BITS-1:0] free_vec;
    logic [BIT_W-1:0]     hit_bit;
    logic                 want;
    logic                 rd_en;
    logic [WADDR_W-1:0]   rd_addr;
    logic                 wr_en;
    logic [WADDR_W-1:0]   wr_addr;
    logic [WORD_BITS-1:0] wr_data;
    logic [WORD_BITS-1:0] idx_onehot;
    logic [WORD_BITS-1:0] hit_onehot;
    logic                 cfg_wr;

    // Effective node count and the position of the last node in use.
    assign n_eff     = (node_count_reg > CNT_W'(MAX_NODES)) ? CNT_W'(MAX_NODES) : node_count_reg;
    assign n_minus1  = n_eff - CNT_W'(1);
    assign last_word = n_minus1[IDX_W-1:BIT_W];
    assign lim_bit   = n_minus1[BIT_W-1:0];
    assign want      = (op_reg == OP_MARK);

    // Words never written since reset read as all free.
    assign data_eff = rd_valid_reg ? rd_data_reg : '0;

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            tail_mask[b] = (chk_addr_reg == last_word) && (BIT_W'(b) > lim_bit);
        end
    end

    assign free_vec = ~data_eff & ~tail_mask;

    always_comb
    begin
        hit_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--)
        begin
            if (free_vec[b])
            begin
                hit_bit = BIT_W'(b);
            end
        end
    end

    assign idx_onehot = WORD_BITS'(1) << idx_reg[BIT_W-1:0];
    assign hit_onehot = WORD_BITS'(1) << hit_bit;

    assign rd_en   = cmd.scan_run | cmd.read_idx;
    assign rd_addr = cmd.scan_run ? scan_reg[WADDR_W-1:0] : idx_reg[IDX_W-1:BIT_W];

    always_comb
    begin
        wr_en   = cmd.alloc_hit | cmd.toggle;
        wr_addr = idx_reg[IDX_W-1:BIT_W];
        wr_data = want ? (data_eff | idx_onehot) : (data_eff & ~idx_onehot);
        if (cmd.alloc_hit)
        begin
            wr_addr = chk_addr_reg;
            wr_data = data_eff | hit_onehot;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            bitmap_mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg  <= bitmap_mem[rd_addr];
            rd_valid_reg <= word_valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            word_valid_reg <= '0;
        end
        else if (wr_en)
        begin
            word_valid_reg[wr_addr] <= 1'b1;
        end
    end

    assign stat.is_alloc  = (op_reg == OP_ALLOC);
    assign stat.is_setclr = (op_reg == OP_MARK) || (op_reg == OP_FREE);
    assign stat.n_zero    = (n_eff == '0);
    assign stat.idx_oor   = ({1'b0, idx_reg} >= n_eff);
    assign stat.scan_hit  = chk_valid_reg && (|free_vec);
    assign stat.scan_end  = chk_valid_reg && !(|free_vec) && (chk_addr_reg == last_word);
    assign stat.bit_match = (data_eff[idx_reg[BIT_W-1:0]] == want);
    assign stat.out_free  = !out_valid_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            op_reg  <= opcode;
            idx_reg <= node_index;
        end
        if (cmd.scan_run)
        begin
            chk_addr_reg <= scan_reg[WADDR_W-1:0];
        end
        if (cmd.alloc_hit)
        begin
            res_status_reg <= ST_DONE;
            res_index_reg  <= {chk_addr_reg, hit_bit};
        end
        else if (cmd.alloc_fail)
        begin
            res_status_reg <= ST_NO_FREE;
            res_index_reg  <= '0;
        end
        else if (cmd.range_err)
        begin
            res_status_reg <= ST_RANGE;
            res_index_reg  <= idx_reg;
        end
        else if (cmd.same_state)
        begin
            res_status_reg <= ST_SAME;
            res_index_reg  <= idx_reg;
        end
        else if (cmd.toggle)
        begin
            res_status_reg <= ST_DONE;
            res_index_reg  <= idx_reg;
        end
        if (cmd.publish)
        begin
            out_status_reg <= res_status_reg;
            out_index_reg  <= res_index_reg;
            out_free_reg   <= (n_eff > total_reg) ? (n_eff - total_reg) : '0;
        end
    end

    assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            node_count_reg <= NODE_COUNT_RESET;
            total_reg      <= '0;
            scan_reg       <= '0;
            chk_valid_reg  <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                node_count_reg <= pwdata[CNT_W-1:0];
            end
            if (cmd.alloc_hit || (cmd.toggle && want))
            begin
                total_reg <= total_reg + CNT_W'(1);
            end
            else if (cmd.toggle && (total_reg != '0))
            begin
                total_reg <= total_reg - CNT_W'(1);
            end
            if (cmd.scan_start)
            begin
                scan_reg <= '0;
            end
            else if (cmd.scan_run)
            begin
                scan_reg <= scan_reg + SCAN_W'(1);
            end
            chk_valid_reg <= cmd.scan_run && (scan_reg <= {1'b0, last_word});
            if (cmd.publish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign prdata       = (paddr[2] == 1'b0) ? {{(32 - CNT_W){1'b0}}, node_count_reg} : '0;
    assign out_valid    = out_valid_reg;
    assign status       = out_status_reg;
    assign result_index = out_index_reg;
    assign free_count   = out_free_reg;

endmodule

// ----- hdl/bitmap_node_allocator.sv -----
// Top level of the first-fit bitmap node allocator: controller, datapath and ports.
// In-range mark or free: decode, read and check the bitmap word, then register the result;
// a rejected command (bad index, undefined opcode, allocate at node count zero) goes from
// decode straight to the result. Allocate scans up to the word with the lowest free node,
// one word per cycle through the memory's single read port. One item is in work at a time;
// the next is taken after the result moves into the output register once that is free.
// Reset (rst_n, asynchronous) marks every word unwritten, so all nodes read as free at once.
module bitmap_node_allocator
    import bna_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         opcode,
    input  logic [IDX_W-1:0]   node_index,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [1:0]         status,
    output logic [IDX_W-1:0]   result_index,
    output logic [CNT_W-1:0]   free_count,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    // The controller only sees status flags and issues one-hot style commands;
    // everything that holds data lives in the datapath.
    bna_cmd_t  cmd;
    bna_stat_t stat;

    // The configuration port never stalls.
    assign pready = 1'b1;

    bna_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // The datapath holds the bitmap, with a valid bit per word so that reset needs
    // no clearing pass, the allocated-node count, the node count register and the
    // output register that lets a finished beat wait while the next item is taken.
    bna_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .opcode       (opcode),
        .node_index   (node_index),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_index (result_index),
        .free_count   (free_count)
    );

endmodule

// ----- hdl/bna_checker.sv -----
// Port-level checks for the node allocator and their binding to the top level.
module bna_assertions
    import bna_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             out_valid,
    input logic             out_ready,
    input logic [1:0]       status,
    input logic [IDX_W-1:0] result_index,
    input logic [CNT_W-1:0] free_count
);

    // A taken input beat closes the input until its work has been done.
    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("input taken twice in a row");

    // A failed allocation reports index zero.
    a_fail_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NO_FREE)) |-> (result_index == '0))
        else $error("allocation failure with non-zero index");

    // When no node could be found, nothing may be counted as free.
    a_fail_count: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_NO_FREE)) |-> (free_count == '0))
        else $error("allocation failure with free nodes left");

    // The free count never exceeds the bitmap size.
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (free_count <= CNT_W'(MAX_NODES)))
        else $error("free count above node capacity");

    // A stalled result beat holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(status) && $stable(result_index) && $stable(free_count)))
        else $error("result beat changed while stalled");

endmodule

bind bitmap_node_allocator bna_assertions u_bna_assertions (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .status       (status),
    .result_index (result_index),
    .free_count   (free_count)
);

// ----- verif/bna_checker.sv -----
// Scoreboard for the node allocator: mirrors the bitmap, predicts every result beat and compares.
module bna_checker
    import bna_pkg::*;
#(
    parameter logic [2:0] NODE_COUNT_ADDR = 3'd0
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             in_ready,
    input  logic [1:0]       opcode,
    input  logic [IDX_W-1:0] node_index,
    input  logic             out_valid,
    input  logic             out_ready,
    input  logic [1:0]       status,
    input  logic [IDX_W-1:0] result_index,
    input  logic [CNT_W-1:0] free_count,
    input  logic             psel,
    input  logic             penable,
    input  logic             pwrite,
    input  logic [2:0]       paddr,
    input  logic [31:0]      pwdata,
    input  logic             pready,
    output int               mismatches,
    output int               outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [1:0]       status;
        logic [IDX_W-1:0] index;
        logic [CNT_W-1:0] free_nodes;
    } alloc_result_t;

    logic [WORD_BITS-1:0] node_map [WORD_COUNT];
    int                   nodes_in_use;
    logic [CNT_W-1:0]     node_limit;
    alloc_result_t        expected_results [$];

    // Applies one command to the mirrored bitmap and returns the beat it must produce.
    function automatic alloc_result_t apply_command(input logic [1:0] op,
                                                    input logic [IDX_W-1:0] idx);
        int            limit;
        int            slot;
        int            target;
        logic          want_set;
        alloc_result_t r;
        limit    = (node_limit > MAX_NODES) ? MAX_NODES : int'(node_limit);
        target   = int'(idx);
        r.status = ST_DONE;
        r.index  = idx;
        if (op == OP_ALLOC)
        begin
            slot = 0;
            while (slot < limit && node_map[slot / WORD_BITS][slot % WORD_BITS])
                slot++;
            if (slot < limit)
            begin
                node_map[slot / WORD_BITS][slot % WORD_BITS] = 1'b1;
                nodes_in_use++;
                r.index = IDX_W'(slot);
            end
            else
            begin
                r.status = ST_NO_FREE;
                r.index  = '0;
            end
        end
        else if (op == OP_MARK || op == OP_FREE)
        begin
            want_set = (op == OP_MARK);
            if (target >= limit)
                r.status = ST_RANGE;
            else if (node_map[target / WORD_BITS][target % WORD_BITS] == want_set)
                r.status = ST_SAME;
            else
            begin
                node_map[target / WORD_BITS][target % WORD_BITS] = want_set;
                if (want_set)
                    nodes_in_use++;
                else if (nodes_in_use != 0)
                    nodes_in_use--;
            end
        end
        else
        begin
            r.status = ST_RANGE;
        end
        // Bits left set above a lowered count still count, so the free figure floors at zero.
        r.free_nodes = (limit > nodes_in_use) ? CNT_W'(limit - nodes_in_use) : '0;
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        alloc_result_t want;
        if (!rst_n)
        begin
            for (int w = 0; w < WORD_COUNT; w++)
                node_map[w] = '0;
            nodes_in_use = 0;
            node_limit   = NODE_COUNT_RESET;
            expected_results.delete();
            mismatches   = 0;
        end
        else
        begin
            // The result beat always belongs to an earlier command, so it is checked first.
            if (out_valid && out_ready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("%0t: unexpected result beat, expected none, got status %0d index %0d free %0d",
                             $time, status, result_index, free_count);
                    mismatches++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (status !== want.status)
                    begin
                        $display("%0t: status expected %0d, got %0d", $time, want.status, status);
                        mismatches++;
                    end
                    if (result_index !== want.index)
                    begin
                        $display("%0t: result_index expected %0d, got %0d",
                                 $time, want.index, result_index);
                        mismatches++;
                    end
                    if (free_count !== want.free_nodes)
                    begin
                        $display("%0t: free_count expected %0d, got %0d",
                                 $time, want.free_nodes, free_count);
                        mismatches++;
                    end
                end
            end
            if (in_valid && in_ready)
                expected_results.push_back(apply_command(opcode, node_index));
            if (psel && penable && pwrite && pready && paddr == NODE_COUNT_ADDR)
                node_limit = pwdata[CNT_W-1:0];
        end
        outstanding = expected_results.size();
    end

endmodule

// ----- verif/tb_bitmap_node_allocator.sv -----
// Testbench top for the bitmap node allocator: stimulus, configuration phases and verdict.
module tb_bitmap_node_allocator;
    import bna_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The node count register is the first and only register, so it sits at byte address 0.
    localparam logic [2:0] REG_NODE_COUNT = 3'd0;
    // Opcode 3 has no meaning; the block must reject it without touching the bitmap.
    localparam logic [1:0] OP_UNDEF       = 2'd3;
    localparam int         PHASE_BEATS    = 95;
    localparam int         PHASES         = 11;

    logic             clk = 1'b0;
    logic             rst_n;
    logic             in_valid;
    logic             in_ready;
    logic [1:0]       opcode;
    logic [IDX_W-1:0] node_index;
    logic             out_valid;
    logic             out_ready;
    logic [1:0]       status;
    logic [IDX_W-1:0] result_index;
    logic [CNT_W-1:0] free_count;
    logic             psel;
    logic             penable;
    logic             pwrite;
    logic [2:0]       paddr;
    logic [31:0]      pwdata;
    logic [31:0]      prdata;
    logic             pready;

    int mismatch_count;
    int results_owed;

    // Gaps on the input side and stalls on the output side are only inserted while this is set.
    logic idle_enable = 1'b0;
    // Effective node count as currently programmed, used to aim indices at the live range.
    int   live_limit  = MAX_NODES;

    bitmap_node_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .node_index   (node_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_index (result_index),
        .free_count   (free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    bna_checker #(
        .NODE_COUNT_ADDR (REG_NODE_COUNT)
    ) u_scoreboard (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .opcode       (opcode),
        .node_index   (node_index),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .status       (status),
        .result_index (result_index),
        .free_count   (free_count),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatch_count),
        .outstanding  (results_owed)
    );

    always #5 clk = ~clk;

    // Safety net. The slowest legal run is roughly 1100 beats, each paying the longest input gap,
    // a full allocate scan and the longest output stall. Four milliseconds leaves ample margin
    // over that.
    initial
    begin
        #4_000_000;
        $display("Test completed with failures");
        $finish;
    end

    // The result side drops out_ready in random bursts while idling is enabled. Each pass
    // through the loop ends with out_ready raised.
    initial
    begin
        int hold;
        out_ready <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 4) == 0)
            begin
                hold = $urandom_range(1, 13);
                out_ready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            out_ready <= 1'b1;
        end
    end

    // Presents one command beat and returns just after the edge that accepted it. Valid is
    // left high so that a following beat can go out back to back; it is only lowered when a
    // gap is inserted or when the stimulus pauses for a drain.
    task automatic send_cmd(input logic [1:0] op, input logic [IDX_W-1:0] idx);
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 13);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        opcode     <= op;
        node_index <= idx;
        // in_ready is looked at mid-cycle, where it is settled, and the beat then goes
        // across at the following rising edge.
        @(negedge clk);
        while (!in_ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    // Parks the input side and waits until every predicted result beat has been seen.
    // The count is read at the falling edge so that the checker has finished its update.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(negedge clk);
        while (results_owed != 0)
            @(negedge clk);
        @(posedge clk);
    endtask

    // APB write of the node count: setup cycle, then access cycle. The bits above the
    // 11-bit field are filled with noise, since the register must ignore them.
    task automatic write_node_count(input int value);
        int kept;
        kept       = value & 32'h7FF;
        psel       <= 1'b1;
        penable    <= 1'b0;
        pwrite     <= 1'b1;
        paddr      <= REG_NODE_COUNT;
        pwdata     <= ($urandom() & 32'hFFFF_F800) | 32'(kept);
        @(posedge clk);
        penable    <= 1'b1;
        @(posedge clk);
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        live_limit  = (kept > MAX_NODES) ? MAX_NODES : kept;
    endtask

    // One random command. Allocates dominate so that the map fills and the scan has to
    // walk further; marks and frees are mostly aimed inside the live range, and often at
    // the low end where allocations cluster, with the rest spread over the whole index
    // field so that every index bit toggles and out-of-range cases appear.
    task automatic send_random_cmd();
        int               roll;
        int               span;
        logic [1:0]       op;
        logic [IDX_W-1:0] idx;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            op = OP_ALLOC;
        else if (roll < 65)
            op = OP_MARK;
        else if (roll < 95)
            op = OP_FREE;
        else
            op = OP_UNDEF;
        roll = $urandom_range(0, 3);
        span = (live_limit < 96) ? live_limit : 96;
        if (live_limit > 0 && roll == 0)
            idx = IDX_W'($urandom_range(0, live_limit - 1));
        else if (live_limit > 0 && roll != 3)
            idx = IDX_W'($urandom_range(0, span - 1));
        else
            idx = IDX_W'($urandom());
        send_cmd(op, idx);
    endtask

    initial
    begin
        int phase_limits [PHASES];

        rst_n      <= 1'b0;
        in_valid   <= 1'b0;
        opcode     <= OP_ALLOC;
        node_index <= '0;
        psel       <= 1'b0;
        penable    <= 1'b0;
        pwrite     <= 1'b0;
        paddr      <= '0;
        pwdata     <= '0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part at the reset node count of 1024, with no idling so that the
        // expected sequence of indices is easy to follow.
        send_cmd(OP_FREE, '0);                 // already free
        send_cmd(OP_ALLOC, {IDX_W{1'b1}});     // index ignored, gets node 0
        send_cmd(OP_ALLOC, '0);                // node 1
        send_cmd(OP_MARK, {IDX_W{1'b1}});      // top node
        send_cmd(OP_MARK, {IDX_W{1'b1}});      // already allocated
        send_cmd(OP_FREE, '0);
        send_cmd(OP_ALLOC, '0);                // reuses node 0
        send_cmd(OP_UNDEF, {IDX_W{1'b1}});     // undefined opcode, reported as out of range
        send_cmd(OP_UNDEF, '0);
        send_cmd(OP_MARK, IDX_W'(2));
        send_cmd(OP_ALLOC, '0);                // skips the marked node, gets node 3
        wait_drained();

        // A count of zero: nothing is in range and allocate finds nothing.
        write_node_count(0);
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_MARK, '0);
        send_cmd(OP_FREE, IDX_W'(1));
        wait_drained();

        // Above the node limit the count behaves as the full 1024.
        write_node_count(2047);
        send_cmd(OP_FREE, {IDX_W{1'b1}});
        send_cmd(OP_MARK, {IDX_W{1'b1}});
        send_cmd(OP_ALLOC, '0);
        wait_drained();

        // Count lowered to one with several nodes still allocated: the free figure is
        // floored at zero and the stale bits above the count keep counting.
        write_node_count(1);
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_FREE, '0);
        send_cmd(OP_ALLOC, '0);
        send_cmd(OP_MARK, IDX_W'(1));
        wait_drained();

        // Random phases, each at its own node count. Small counts let the map fill up
        // and hit the no-free case; the jump from 300 down to 33 and 5 leaves many
        // allocated nodes stranded above the count. One phase takes a random count.
        phase_limits = '{40, 1024, 0, 2047, 1, 300, 33, 5, 0, 64, 1024};
        phase_limits[8] = $urandom_range(1, 1024);
        for (int phase = 0; phase < PHASES; phase++)
        begin
            write_node_count(phase_limits[phase]);
            // The closing phase runs without any idling; earlier ones mostly idle,
            // though some run flat out to give long unbroken stretches.
            idle_enable = (phase != PHASES - 1) && ($urandom_range(0, 3) != 0);
            repeat (PHASE_BEATS) send_random_cmd();
            wait_drained();
        end

        // Everything has come back; keep the clock running so that any spurious result beat
        // shows before the verdict.
        repeat (40) @(posedge clk);
        if (mismatch_count == 0 && results_owed == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- files.f -----
hdl/bna_pkg.sv
hdl/bna_ctrl.sv
hdl/bna_dp.sv
hdl/bitmap_node_allocator.sv
hdl/bna_checker.sv
verif/bna_checker.sv
verif/tb_bitmap_node_allocator.sv
